// ===== rtl/rau_pkg.sv =====
`default_nettype none

package rau_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_EQ  = 4'd4,
    OP_NE  = 4'd5,
    OP_GT  = 4'd6,
    OP_LT  = 4'd7,
    OP_GE  = 4'd8,
    OP_LE  = 4'd9,
    OP_RED = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_MUL,
    ST_GCD,
    ST_DVLD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic gcd_step;
    logic div_load;
    logic div_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic needs_mul;
    logic needs_gcd;
    logic mul_last;
    logic gcd_done;
    logic div_last;
  } status_t;

  localparam int unsigned DigitW = 16;

endpackage

`default_nettype wire

// ===== rtl/rau_ctrl.sv =====
`default_nettype none

module rau_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire rau_pkg::status_t status_i,
  output rau_pkg::cmd_t        cmd_o
);

  rau_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rau_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rau_pkg::ST_DISP;
      end
      rau_pkg::ST_DISP: begin
        priority if (status_i.needs_mul) state_d = rau_pkg::ST_MUL;
        else if (status_i.needs_gcd) state_d = rau_pkg::ST_GCD;
        else state_d = rau_pkg::ST_FIN;
      end
      rau_pkg::ST_MUL: begin
        if (status_i.mul_last) state_d = rau_pkg::ST_FIN;
      end
      rau_pkg::ST_GCD: begin
        if (status_i.gcd_done) state_d = rau_pkg::ST_DVLD;
      end
      rau_pkg::ST_DVLD: begin
        state_d = rau_pkg::ST_DIV;
      end
      rau_pkg::ST_DIV: begin
        if (status_i.div_last) state_d = rau_pkg::ST_FIN;
      end
      rau_pkg::ST_FIN: begin
        if (slot_free) state_d = rau_pkg::ST_IDLE;
      end
      default: state_d = rau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == rau_pkg::ST_IDLE) && in_valid_i;
    cmd_o.mul_step = (state_q == rau_pkg::ST_MUL);
    cmd_o.gcd_step = (state_q == rau_pkg::ST_GCD) && !status_i.gcd_done;
    cmd_o.div_load = (state_q == rau_pkg::ST_DVLD);
    cmd_o.div_step = (state_q == rau_pkg::ST_DIV);
    cmd_o.res_load = (state_q == rau_pkg::ST_FIN) && slot_free;
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  assign in_stall_o  = (state_q != rau_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rau_dp.sv =====
`default_nettype none

module rau_dp #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [3:0]         op_i,
  input  wire logic signed [31:0] a_num_i,
  input  wire logic signed [31:0] a_den_i,
  input  wire logic signed [31:0] b_num_i,
  input  wire logic signed [31:0] b_den_i,
  input  wire rau_pkg::cmd_t      cmd_i,
  output rau_pkg::status_t        status_o,
  output logic signed [31:0]      res_num_o,
  output logic signed [31:0]      res_den_o,
  output logic                    flag_o
);

  localparam int unsigned InW  = (WIDTH < 32) ? WIDTH : 32;
  localparam int unsigned DW   = rau_pkg::DigitW;
  localparam int unsigned ND   = (WIDTH + DW - 1) / DW;
  localparam int unsigned DCW  = (ND > 1) ? $clog2(ND) : 1;
  localparam int unsigned CW   = $clog2(WIDTH);

  rau_pkg::op_e       op_q;
  logic [WIDTH-1:0]   an_q, ad_q, bn_q, bd_q;

  logic [1:0]         slot_q;
  logic [DCW-1:0]     dig_q;
  logic [WIDTH-1:0]   acc_q;
  logic [WIDTH-1:0]   p_q [3];

  logic [WIDTH-1:0]   gx_q, gy_q;
  logic [CW-1:0]      gk_q;

  logic [WIDTH-1:0]   dv_q;
  logic [WIDTH:0]     r1_q, r2_q;
  logic [WIDTH-1:0]   q1_q, q2_q;
  logic [CW-1:0]      cnt_q;

  logic [WIDTH-1:0]   rn_q, rd_q;
  logic               fl_q;

  logic               is_cross, two_prod, den_eq, an_pos, ad_pos;

  always_comb begin
    unique case (op_q)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_EQ, rau_pkg::OP_NE,
      rau_pkg::OP_GT, rau_pkg::OP_LT, rau_pkg::OP_GE, rau_pkg::OP_LE: is_cross = 1'b1;
      default: is_cross = 1'b0;
    endcase
  end

  assign two_prod = (op_q == rau_pkg::OP_MUL) || (op_q == rau_pkg::OP_DIV);
  assign den_eq   = (ad_q == bd_q);
  assign an_pos   = !an_q[WIDTH-1] && (an_q != '0);
  assign ad_pos   = !ad_q[WIDTH-1] && (ad_q != '0);

  // Multiplier: one DW-bit digit of the second operand per cycle, low WIDTH bits kept.
  logic [WIDTH-1:0]    mx, my;
  logic [WIDTH+DW-1:0] ysh, prod;
  logic [DW-1:0]       ydig;
  logic [WIDTH-1:0]    part, acc_next;
  logic                dig_last, slot_last;

  always_comb begin
    unique case (slot_q)
      2'd0: begin
        mx = an_q;
        my = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mx = ad_q;
        my = (op_q == rau_pkg::OP_MUL) ? bd_q : bn_q;
      end
      default: begin
        mx = ad_q;
        my = bd_q;
      end
    endcase
  end

  assign ysh       = {{DW{1'b0}}, my} >> (DW * dig_q);
  assign ydig      = ysh[DW-1:0];
  assign prod      = (WIDTH + DW)'(mx) * (WIDTH + DW)'(ydig);
  assign part      = WIDTH'(prod << (DW * dig_q));
  assign acc_next  = ((dig_q == '0) ? '0 : acc_q) + part;
  assign dig_last  = (dig_q == DCW'(ND - 1));
  assign slot_last = (slot_q == (two_prod ? 2'd1 : 2'd2));

  // Binary gcd step.
  logic [WIDTH-1:0] gx_d, gy_d;
  logic [CW-1:0]    gk_d;

  always_comb begin
    gx_d = gx_q;
    gy_d = gy_q;
    gk_d = gk_q;
    priority if (!gx_q[0] && !gy_q[0]) begin
      gx_d = gx_q >> 1;
      gy_d = gy_q >> 1;
      gk_d = gk_q + CW'(1);
    end else if (!gx_q[0]) begin
      gx_d = gx_q >> 1;
    end else if (!gy_q[0]) begin
      gy_d = gy_q >> 1;
    end else if (gx_q > gy_q) begin
      gx_d = gx_q - gy_q;
    end else begin
      gy_d = gy_q - gx_q;
    end
  end

  // Restoring division of both parts by the common divisor.
  logic [WIDTH:0] sh1, sh2;
  logic           ge1, ge2;

  assign sh1 = {r1_q[WIDTH-1:0], q1_q[WIDTH-1]};
  assign sh2 = {r2_q[WIDTH-1:0], q2_q[WIDTH-1]};
  assign ge1 = (sh1 >= {1'b0, dv_q});
  assign ge2 = (sh2 >= {1'b0, dv_q});

  // Result selection.
  logic [WIDTH-1:0] cn_a, cn_b, cd, rn_d, rd_d;
  logic             fl_d, gt_ab, gt_ba;

  assign cn_a  = den_eq ? an_q : p_q[0];
  assign cn_b  = den_eq ? bn_q : p_q[1];
  assign cd    = den_eq ? ad_q : p_q[2];
  assign gt_ab = ($signed(cn_a) > $signed(cn_b));
  assign gt_ba = ($signed(cn_b) > $signed(cn_a));

  always_comb begin
    rn_d = '0;
    rd_d = '0;
    fl_d = 1'b0;
    unique case (op_q)
      rau_pkg::OP_ADD: begin
        rn_d = cn_a + cn_b;
        rd_d = cd;
      end
      rau_pkg::OP_SUB: begin
        rn_d = cn_a - cn_b;
        rd_d = cd;
      end
      rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
        rn_d = p_q[0];
        rd_d = p_q[1];
      end
      rau_pkg::OP_EQ: fl_d = (cn_a == cn_b);
      rau_pkg::OP_NE: fl_d = (cn_a != cn_b);
      rau_pkg::OP_GT: fl_d = gt_ab;
      rau_pkg::OP_LT: fl_d = gt_ba;
      rau_pkg::OP_GE: fl_d = !gt_ba;
      rau_pkg::OP_LE: fl_d = !gt_ab;
      rau_pkg::OP_RED: begin
        priority if (an_q == '0) begin
          rn_d = '0;
          rd_d = WIDTH'(1);
        end else if (an_q == ad_q) begin
          rn_d = WIDTH'(1);
          rd_d = WIDTH'(1);
        end else if (!an_pos || !ad_pos) begin
          rn_d = an_q;
          rd_d = ad_q;
        end else begin
          rn_d = q1_q;
          rd_d = q2_q;
        end
      end
      default: begin
        rn_d = '0;
        rd_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= rau_pkg::op_e'(op_i);
      an_q <= WIDTH'(a_num_i[InW-1:0]);
      ad_q <= WIDTH'(a_den_i[InW-1:0]);
      bn_q <= WIDTH'(b_num_i[InW-1:0]);
      bd_q <= WIDTH'(b_den_i[InW-1:0]);
      gx_q <= WIDTH'(a_num_i[InW-1:0]);
      gy_q <= WIDTH'(a_den_i[InW-1:0]);
    end else if (cmd_i.gcd_step) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_next;
      if (dig_last) p_q[slot_q] <= acc_next;
    end
    if (cmd_i.div_load) begin
      dv_q <= gx_q << gk_q;
      r1_q <= '0;
      r2_q <= '0;
      q1_q <= an_q;
      q2_q <= ad_q;
    end else if (cmd_i.div_step) begin
      r1_q <= ge1 ? (sh1 - {1'b0, dv_q}) : sh1;
      r2_q <= ge2 ? (sh2 - {1'b0, dv_q}) : sh2;
      q1_q <= {q1_q[WIDTH-2:0], ge1};
      q2_q <= {q2_q[WIDTH-2:0], ge2};
    end
    if (cmd_i.res_load) begin
      rn_q <= rn_d;
      rd_q <= rd_d;
      fl_q <= fl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      dig_q  <= '0;
      gk_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        slot_q <= '0;
        dig_q  <= '0;
        gk_q   <= '0;
      end else begin
        if (cmd_i.mul_step) begin
          if (dig_last) begin
            dig_q  <= '0;
            slot_q <= slot_q + 2'd1;
          end else begin
            dig_q <= dig_q + DCW'(1);
          end
        end
        if (cmd_i.gcd_step) gk_q <= gk_d;
      end
      if (cmd_i.div_load) cnt_q <= '0;
      else if (cmd_i.div_step) cnt_q <= cnt_q + CW'(1);
    end
  end

  assign status_o.needs_mul = two_prod || (is_cross && !den_eq);
  assign status_o.needs_gcd = (op_q == rau_pkg::OP_RED) && (an_q != ad_q) && an_pos && ad_pos;
  assign status_o.mul_last  = dig_last && slot_last;
  assign status_o.gcd_done  = (gx_q == gy_q);
  assign status_o.div_last  = (cnt_q == CW'(WIDTH - 1));

  assign res_num_o = 32'($signed(rn_q));
  assign res_den_o = 32'($signed(rd_q));
  assign flag_o    = fl_q;

endmodule

`default_nettype wire

// ===== rtl/rational_alu_unit.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  op_i, a_num_i, a_den_i, b_num_i, b_den_i
// out      output     out_valid_o / out_stall_i res_num_o, res_den_o, flag_o
//
// One item at a time; a transfer on in starts it and the result lands in an output register.
// Add, sub and compares with equal denominators, and reduce without a gcd, skip the multiplier.
// Cross products take three products and mul and div two, all from the 16-bit digit multiplier.
// Reduce with a gcd runs the binary gcd loop of one shift or subtract per cycle, then a
// restoring division of both parts by the gcd.
// A stalled result holds in the output register while the next item is taken in.
// Reset clears the controller and the output valid; no clearing pass is needed.
`default_nettype none

module rational_alu_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [3:0]         op_i,
  input  wire logic signed [31:0] a_num_i,
  input  wire logic signed [31:0] a_den_i,
  input  wire logic signed [31:0] b_num_i,
  input  wire logic signed [31:0] b_den_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      res_num_o,
  output logic signed [31:0]      res_den_o,
  output logic                    flag_o
);

  rau_pkg::cmd_t    cmd;
  rau_pkg::status_t status;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rau_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .flag_o    (flag_o)
  );

endmodule

`default_nettype wire
